// File: rtl/assert_macros.svh
// Assertion helpers used by spp_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising clk edge outside of reset.
`define SPP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that cond never holds outside of reset.
`define SPP_NEVER(label, clk, rst, cond, msg) \
   `SPP_ASSERT(label, clk, rst, !(cond), msg)

`endif

// File: rtl/spp_pkg.sv
package spp_pkg;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_PROTOCOL   = 2'd1,
      ST_FLOW       = 2'd2,
      ST_FRAME_SIZE = 2'd3
   } status_type;

   typedef enum logic {
      OP_BEGIN = 1'b0,
      OP_BYTE  = 1'b1
   } opcode_type;

   localparam logic [15:0] ID_TABLE_SIZE  = 16'd1;
   localparam logic [15:0] ID_ENABLE_PUSH = 16'd2;
   localparam logic [15:0] ID_STREAMS     = 16'd3;
   localparam logic [15:0] ID_WINDOW      = 16'd4;
   localparam logic [15:0] ID_FRAME_SIZE  = 16'd5;
   localparam logic [15:0] ID_LIST_SIZE   = 16'd6;

   // Index of the last byte of a six-byte entry.
   localparam logic [2:0] ENTRY_LAST = 3'd5;

   typedef struct packed {
      logic        opcode;
      logic [23:0] frame_len;
      logic [7:0]  data_byte;
   } item_type;

   typedef struct packed {
      logic [31:0] table_size;
      logic        push_enabled;
      logic [31:0] stream_limit;
      logic        stream_limit_seen;
      logic [30:0] window_size;
      logic [23:0] frame_limit;
      logic [31:0] header_list_limit;
      logic        header_list_seen;
   } settings_type;

   typedef struct packed {
      status_type   status;
      settings_type settings;
   } result_type;

   localparam settings_type SETTINGS_RESET = '{
      table_size:        32'd4096,
      push_enabled:      1'b1,
      stream_limit:      32'd0,
      stream_limit_seen: 1'b0,
      window_size:       31'd65535,
      frame_limit:       24'd16384,
      header_list_limit: 32'd0,
      header_list_seen:  1'b0
   };

   // x mod 3 for x below 32.
   localparam logic [1:0] MOD3_LUT [32] = '{
      2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1,
      2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0,
      2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2,
      2'd0, 2'd1, 2'd2, 2'd0, 2'd1, 2'd2, 2'd0, 2'd1
   };

   // True when len is a multiple of six: even, and a multiple of three.
   // Mod 3 folds nibbles, since 16 is 1 mod 3.
   function automatic logic len_multiple_of_6(input logic [23:0] len);
      logic [6:0] nib_sum;
      logic [4:0] fold;
      nib_sum = '0;
      for (int i = 0; i < 6; i++) begin
         nib_sum = nib_sum + {3'd0, len[4*i +: 4]};
      end
      fold = {1'b0, nib_sum[3:0]} + {2'd0, nib_sum[6:4]};
      return (len[0] == 1'b0) && (MOD3_LUT[fold] == 2'd0);
   endfunction

endpackage

// File: rtl/settings_payload_parser.sv
// A result word passes through the input register and then the result register before it
// is on rsp_; a full result register can hold it back between the two.
// Throughput: one word per cycle, set by the single pass from input register to result register.
// A result word left waiting by rsp_ready stalls the input register, result or not for the next.
// Reset (synchronous, active high): no frame open, no error latched, settings at protocol
// defaults (table 4096, push on, window 65535, frame limit 16384), both registers empty.
module settings_payload_parser
   import spp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [23:0] req_frame_len,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_table_size,
   output logic        rsp_push_enabled,
   output logic [31:0] rsp_stream_limit,
   output logic        rsp_stream_limit_seen,
   output logic [30:0] rsp_window_size,
   output logic [23:0] rsp_frame_limit,
   output logic [31:0] rsp_header_list_limit,
   output logic        rsp_header_list_seen
);

   logic       item_valid;
   item_type   item;
   logic       take;
   logic       emit;
   logic       out_free;
   result_type result;

   // Input register: hold one word; refill as it drains.
   spp_in_reg u_in_reg (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_frame_len (req_frame_len),
      .req_data_byte (req_data_byte),
      .take          (take),
      .item_valid    (item_valid),
      .item          (item)
   );

   // Parser state: assemble entries, check and apply them, decide the result.
   // Advance only when the result register has room, so no result is dropped.
   spp_core u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .emit       (emit),
      .result     (result)
   );

   // Result register: hold a result word until rsp_ready.
   spp_out_reg u_out_reg (
      .clock                 (clock),
      .reset                 (reset),
      .load                  (emit),
      .result                (result),
      .out_free              (out_free),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_table_size        (rsp_table_size),
      .rsp_push_enabled      (rsp_push_enabled),
      .rsp_stream_limit      (rsp_stream_limit),
      .rsp_stream_limit_seen (rsp_stream_limit_seen),
      .rsp_window_size       (rsp_window_size),
      .rsp_frame_limit       (rsp_frame_limit),
      .rsp_header_list_limit (rsp_header_list_limit),
      .rsp_header_list_seen  (rsp_header_list_seen)
   );

endmodule

// File: rtl/spp_in_reg.sv
module spp_in_reg
   import spp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [23:0] req_frame_len,
   input  logic [7:0]  req_data_byte,
   input  logic        take,
   output logic        item_valid,
   output item_type    item
);

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;

   // Refill in the same cycle the held word drains.
   assign req_ready = !valid_ff || take;
   assign valid_in  = req_valid || (valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && req_ready) begin
         item_ff <= '{opcode: req_opcode, frame_len: req_frame_len,
                      data_byte: req_data_byte};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// File: rtl/spp_core.sv
`include "assert_macros.svh"

module spp_core
   import spp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       item_valid,
   input  item_type   item,
   input  logic       out_free,
   output logic       take,
   output logic       emit,
   output result_type result
);

   logic [23:0]  bytes_left_ff, bytes_left_in;
   logic [2:0]   entry_pos_ff, entry_pos_in;
   logic [39:0]  entry_shift_ff, entry_shift_in;
   status_type   error_ff, error_in;
   settings_type kept_ff, kept_in;

   logic [23:0]  left_dec;
   logic [15:0]  entry_id;
   logic [31:0]  entry_val;
   status_type   status_out;
   logic         emit_int;

   assign take      = item_valid && out_free;
   assign left_dec  = bytes_left_ff - 24'd1;
   assign entry_id  = entry_shift_ff[39:24];
   assign entry_val = {entry_shift_ff[23:0], item.data_byte};

   always_comb begin
      bytes_left_in  = bytes_left_ff;
      entry_pos_in   = entry_pos_ff;
      entry_shift_in = entry_shift_ff;
      error_in       = error_ff;
      kept_in        = kept_ff;
      status_out     = ST_OK;
      emit_int       = 1'b0;

      if (opcode_type'(item.opcode) == OP_BEGIN) begin
         entry_pos_in   = '0;
         entry_shift_in = '0;
         bytes_left_in  = item.frame_len;
         if (item.frame_len == '0) begin
            error_in = ST_OK;
            emit_int = 1'b1;
         end else if (!len_multiple_of_6(item.frame_len)) begin
            error_in   = ST_FRAME_SIZE;
            status_out = ST_FRAME_SIZE;
            emit_int   = 1'b1;
         end else begin
            error_in = ST_OK;
         end
      end else if (bytes_left_ff != '0) begin
         bytes_left_in = left_dec;
         if (error_ff != ST_FRAME_SIZE) begin
            if (entry_pos_ff >= ENTRY_LAST) begin
               entry_pos_in   = '0;
               entry_shift_in = '0;
               if (error_ff == ST_OK) begin
                  case (entry_id)
                     ID_TABLE_SIZE: kept_in.table_size = entry_val;
                     ID_ENABLE_PUSH: begin
                        if (entry_val > 32'd1) error_in = ST_PROTOCOL;
                        else kept_in.push_enabled = entry_val[0];
                     end
                     ID_STREAMS: begin
                        kept_in.stream_limit      = entry_val;
                        kept_in.stream_limit_seen = 1'b1;
                     end
                     ID_WINDOW: begin
                        if (entry_val[31]) error_in = ST_FLOW;
                        else kept_in.window_size = entry_val[30:0];
                     end
                     ID_FRAME_SIZE: begin
                        // legal range is 2^14 .. 2^24-1
                        if (entry_val[31:24] != '0 || entry_val[23:14] == '0)
                           error_in = ST_PROTOCOL;
                        else kept_in.frame_limit = entry_val[23:0];
                     end
                     ID_LIST_SIZE: begin
                        kept_in.header_list_limit = entry_val;
                        kept_in.header_list_seen  = 1'b1;
                     end
                     default: ;
                  endcase
               end
            end else begin
               entry_shift_in = {entry_shift_ff[31:0], item.data_byte};
               entry_pos_in   = entry_pos_ff + 3'd1;
            end
         end
         if (left_dec == '0) begin
            entry_pos_in   = '0;
            entry_shift_in = '0;
            if (error_ff == ST_FRAME_SIZE) begin
               // swallowed frame ends quietly
               error_in = ST_OK;
            end else begin
               status_out = error_in;
               emit_int   = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_left_ff  <= '0;
         entry_pos_ff   <= '0;
         entry_shift_ff <= '0;
         error_ff       <= ST_OK;
         kept_ff        <= SETTINGS_RESET;
      end else if (take) begin
         bytes_left_ff  <= bytes_left_in;
         entry_pos_ff   <= entry_pos_in;
         entry_shift_ff <= entry_shift_in;
         error_ff       <= error_in;
         kept_ff        <= kept_in;
      end
   end

   assign emit   = take && emit_int;
   assign result = '{status: status_out, settings: kept_in};

   `SPP_ASSERT(a_pos_range, clock, reset, entry_pos_ff <= ENTRY_LAST,
      "entry position past the last byte of an entry")
   `SPP_ASSERT(a_idle_clean, clock, reset,
      (bytes_left_ff == '0) |-> (entry_pos_ff == '0 && entry_shift_ff == '0),
      "partial entry left over with no frame open")
   `SPP_NEVER(a_swallow_open, clock, reset,
      error_ff == ST_FRAME_SIZE && bytes_left_ff == '0,
      "frame size latch held with no frame open")
   `SPP_ASSERT(a_emit_needs_room, clock, reset, emit |-> out_free,
      "result produced while the result register is full")

endmodule

// File: rtl/spp_out_reg.sv
module spp_out_reg
   import spp_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  result_type  result,
   output logic        out_free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_status,
   output logic [31:0] rsp_table_size,
   output logic        rsp_push_enabled,
   output logic [31:0] rsp_stream_limit,
   output logic        rsp_stream_limit_seen,
   output logic [30:0] rsp_window_size,
   output logic [23:0] rsp_frame_limit,
   output logic [31:0] rsp_header_list_limit,
   output logic        rsp_header_list_seen
);

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign valid_in = load || (valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid             = valid_ff;
   assign rsp_status            = result_ff.status;
   assign rsp_table_size        = result_ff.settings.table_size;
   assign rsp_push_enabled      = result_ff.settings.push_enabled;
   assign rsp_stream_limit      = result_ff.settings.stream_limit;
   assign rsp_stream_limit_seen = result_ff.settings.stream_limit_seen;
   assign rsp_window_size       = result_ff.settings.window_size;
   assign rsp_frame_limit       = result_ff.settings.frame_limit;
   assign rsp_header_list_limit = result_ff.settings.header_list_limit;
   assign rsp_header_list_seen  = result_ff.settings.header_list_seen;

endmodule

// File: sim/parser_check_pkg.sv
package parser_check_pkg;
   import spp_pkg::*;

   localparam int unsigned ENTRY_BYTES = 6;
   localparam logic [31:0] FRAME_LIMIT_MIN = 32'd16384;
   localparam logic [31:0] FRAME_LIMIT_MAX = 32'd16777215;
   localparam logic [31:0] WINDOW_MAX = 32'h7FFF_FFFF;

   // Tracks the parser state word by word and keeps the reports it must give.
   class settings_scoreboard;
      settings_type kept;
      logic [23:0]  bytes_left;
      logic [2:0]   entry_pos;
      logic [39:0]  entry_shift;
      status_type   err_latch;
      result_type   expected_reports[$];
      int unsigned  mismatches;

      function new();
         kept.table_size        = 32'd4096;
         kept.push_enabled      = 1'b1;
         kept.stream_limit      = 32'd0;
         kept.stream_limit_seen = 1'b0;
         kept.window_size       = 31'd65535;
         kept.frame_limit       = 24'd16384;
         kept.header_list_limit = 32'd0;
         kept.header_list_seen  = 1'b0;
         bytes_left  = '0;
         entry_pos   = '0;
         entry_shift = '0;
         err_latch   = ST_OK;
         mismatches  = 0;
      endfunction

      function void queue_report(status_type st);
         result_type r;
         r.status   = st;
         r.settings = kept;
         expected_reports.push_back(r);
      endfunction

      function void apply_setting(logic [15:0] id, logic [31:0] value);
         case (id)
            ID_TABLE_SIZE:  kept.table_size = value;
            ID_ENABLE_PUSH: begin
               if (value > 32'd1) err_latch = ST_PROTOCOL;
               else kept.push_enabled = value[0];
            end
            ID_STREAMS: begin
               kept.stream_limit      = value;
               kept.stream_limit_seen = 1'b1;
            end
            ID_WINDOW: begin
               if (value > WINDOW_MAX) err_latch = ST_FLOW;
               else kept.window_size = value[30:0];
            end
            ID_FRAME_SIZE: begin
               if (value < FRAME_LIMIT_MIN || value > FRAME_LIMIT_MAX) err_latch = ST_PROTOCOL;
               else kept.frame_limit = value[23:0];
            end
            ID_LIST_SIZE: begin
               kept.header_list_limit = value;
               kept.header_list_seen  = 1'b1;
            end
            default: ;
         endcase
      endfunction

      // Advance the parser by one accepted word.
      function void parse_word(opcode_type op, logic [23:0] len, logic [7:0] data);
         status_type st;
         if (op == OP_BEGIN) begin
            entry_pos   = '0;
            entry_shift = '0;
            bytes_left  = len;
            if (len == 24'd0) begin
               err_latch = ST_OK;
               queue_report(ST_OK);
            end else if (len % ENTRY_BYTES != 0) begin
               err_latch = ST_FRAME_SIZE;
               queue_report(ST_FRAME_SIZE);
            end else begin
               err_latch = ST_OK;
            end
            return;
         end
         if (bytes_left == 24'd0) return;
         bytes_left = bytes_left - 24'd1;
         if (err_latch != ST_FRAME_SIZE) begin
            if (entry_pos >= ENTRY_LAST) begin
               if (err_latch == ST_OK) apply_setting(entry_shift[39:24], {entry_shift[23:0], data});
               entry_pos   = '0;
               entry_shift = '0;
            end else begin
               entry_shift = {entry_shift[31:0], data};
               entry_pos   = entry_pos + 3'd1;
            end
         end
         if (bytes_left == 24'd0) begin
            st          = err_latch;
            entry_pos   = '0;
            entry_shift = '0;
            if (st == ST_FRAME_SIZE) err_latch = ST_OK;
            else queue_report(st);
         end
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
         end
      endfunction

      function void check_report(result_type got);
         result_type want;
         if (expected_reports.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("result with no expectation waiting: status %0d", got.status);
            return;
         end
         want = expected_reports.pop_front();
         compare_field("status", 32'(want.status), 32'(got.status));
         compare_field("table_size", want.settings.table_size, got.settings.table_size);
         compare_field("push_enabled", 32'(want.settings.push_enabled),
                       32'(got.settings.push_enabled));
         compare_field("stream_limit", want.settings.stream_limit, got.settings.stream_limit);
         compare_field("stream_limit_seen", 32'(want.settings.stream_limit_seen),
                       32'(got.settings.stream_limit_seen));
         compare_field("window_size", 32'(want.settings.window_size),
                       32'(got.settings.window_size));
         compare_field("frame_limit", 32'(want.settings.frame_limit),
                       32'(got.settings.frame_limit));
         compare_field("header_list_limit", want.settings.header_list_limit,
                       got.settings.header_list_limit);
         compare_field("header_list_seen", 32'(want.settings.header_list_seen),
                       32'(got.settings.header_list_seen));
      endfunction
   endclass

endpackage

// File: sim/tb_top.sv
module tb_top;
   import spp_pkg::*;
   import parser_check_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // Give up after this many cycles in which no word moves on either side.
   localparam int unsigned STALL_LIMIT = 2000;
   // Words per random phase; four phases give about 600 in all.
   localparam int unsigned PHASE_WORDS = 150;
   // Cycles to keep watching after the last expected result.
   localparam int unsigned DRAIN_CYCLES = 10;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic        req_opcode;
   logic [23:0] req_frame_len;
   logic [7:0]  req_data_byte;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_status;
   logic [31:0] rsp_table_size;
   logic        rsp_push_enabled;
   logic [31:0] rsp_stream_limit;
   logic        rsp_stream_limit_seen;
   logic [30:0] rsp_window_size;
   logic [23:0] rsp_frame_limit;
   logic [31:0] rsp_header_list_limit;
   logic        rsp_header_list_seen;

   settings_scoreboard sb = new();

   // Percent of cycles in which the sender holds off and the receiver stalls.
   int unsigned send_gap_pct  = 0;
   int unsigned rsp_stall_pct = 0;
   // Words sent, and stray words among them (those do not count as stimulus).
   int unsigned words_sent  = 0;
   int unsigned stray_words = 0;
   int unsigned idle_cycles = 0;

   settings_payload_parser dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_opcode            (req_opcode),
      .req_frame_len         (req_frame_len),
      .req_data_byte         (req_data_byte),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_status            (rsp_status),
      .rsp_table_size        (rsp_table_size),
      .rsp_push_enabled      (rsp_push_enabled),
      .rsp_stream_limit      (rsp_stream_limit),
      .rsp_stream_limit_seen (rsp_stream_limit_seen),
      .rsp_window_size       (rsp_window_size),
      .rsp_frame_limit       (rsp_frame_limit),
      .rsp_header_list_limit (rsp_header_list_limit),
      .rsp_header_list_seen  (rsp_header_list_seen)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Receiver side: decide the stall at the falling edge, take the result word
   // at the rising edge and hand it to the scoreboard.
   always @(negedge clock) begin
      rsp_ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.status                     = status_type'(rsp_status);
         got.settings.table_size        = rsp_table_size;
         got.settings.push_enabled      = rsp_push_enabled;
         got.settings.stream_limit      = rsp_stream_limit;
         got.settings.stream_limit_seen = rsp_stream_limit_seen;
         got.settings.window_size       = rsp_window_size;
         got.settings.frame_limit       = rsp_frame_limit;
         got.settings.header_list_limit = rsp_header_list_limit;
         got.settings.header_list_seen  = rsp_header_list_seen;
         sb.check_report(got);
      end
   end

   // Watchdog: count cycles in which no word moves in either direction.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // Present one word at a falling edge, hold it until the rising edge that
   // accepts it, then note it. Returns at the next falling edge with valid
   // still high, so the following word can go out back to back.
   task automatic send_word(input opcode_type op, input logic [23:0] len,
                            input logic [7:0] data);
      while (send_gap_pct != 0 && $urandom_range(99) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_frame_len <= len;
      req_data_byte <= data;
      do @(posedge clock); while (!req_ready);
      sb.parse_word(op, len, data);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic send_begin(input logic [23:0] len);
      send_word(OP_BEGIN, len, 8'($urandom));
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_word(OP_BYTE, 24'($urandom), data);
   endtask

   // Send one entry: 16-bit id then 32-bit value, most significant byte first.
   task automatic send_entry(input logic [15:0] id, input logic [31:0] value);
      logic [47:0] packed_entry;
      packed_entry = {id, value};
      for (int i = 0; i < ENTRY_BYTES; i++) begin
         send_byte(packed_entry[47 - 8*i -: 8]);
      end
   endtask

   // Mostly known ids, some unknown ones near them, some anywhere in 16 bits.
   function automatic logic [15:0] pick_id();
      int unsigned roll;
      roll = $urandom_range(99);
      if (roll < 75) return 16'($urandom_range(ID_TABLE_SIZE, ID_LIST_SIZE));
      if (roll < 85) return ($urandom_range(1) != 0) ? 16'd0 : 16'd7;
      return 16'($urandom);
   endfunction

   // Favor the edges of every range check; keep push mostly legal.
   function automatic logic [31:0] pick_value(input logic [15:0] id);
      if (id == ID_ENABLE_PUSH && $urandom_range(99) < 60) return 32'($urandom_range(1));
      if ($urandom_range(99) < 40) return $urandom;
      case ($urandom_range(9))
         0: return 32'd0;
         1: return 32'd1;
         2: return 32'd2;
         3: return FRAME_LIMIT_MIN - 32'd1;
         4: return FRAME_LIMIT_MIN;
         5: return FRAME_LIMIT_MAX;
         6: return FRAME_LIMIT_MAX + 32'd1;
         7: return WINDOW_MAX;
         8: return WINDOW_MAX + 32'd1;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   task automatic send_frame(input int unsigned entries);
      logic [15:0] id;
      send_begin(24'(entries * ENTRY_BYTES));
      repeat (entries) begin
         id = pick_id();
         send_entry(id, pick_value(id));
      end
   endtask

   // Lower valid and hold the sender until every expected result is back.
   task automatic wait_for_reports();
      req_valid <= 1'b0;
      @(negedge clock);
      while (sb.expected_reports.size() != 0) @(negedge clock);
   endtask

   // One random piece of traffic: mostly well-formed frames with random content,
   // some followed by stray bytes; the rest empty frames, bad lengths and abandoned frames.
   task automatic send_random_traffic();
      int unsigned roll;
      int unsigned len;
      int unsigned count;
      roll = $urandom_range(99);
      if (roll < 65) begin
         send_frame($urandom_range(1, 4));
         // Drop a stray byte or two once the frame is closed.
         if ($urandom_range(99) < 10) begin
            repeat ($urandom_range(1, 2)) begin
               send_byte(8'($urandom));
               stray_words++;
            end
         end
      end else if (roll < 70) begin
         send_begin(24'd0);
      end else if (roll < 82) begin
         // Bad length: either swallow the whole frame or cut it short.
         do len = $urandom_range(1, 40); while (len % ENTRY_BYTES == 0);
         send_begin(24'(len));
         count = ($urandom_range(99) < 70) ? len : $urandom_range(0, len - 1);
         repeat (count) send_byte(8'($urandom));
      end else begin
         // Abandoned frame: any length, a few bytes, then the next begin cuts it off.
         len = ($urandom_range(1) != 0) ? $urandom_range(0, 32'hFF_FFFF)
                                        : ENTRY_BYTES * $urandom_range(1, 4);
         send_begin(24'(len));
         if (len != 0) begin
            count = (len > 12) ? $urandom_range(0, 12) : $urandom_range(0, len - 1);
            repeat (count) send_byte(8'($urandom));
         end
      end
   endtask

   initial begin
      int unsigned gap_by_phase[4];
      int unsigned stall_by_phase[4];
      int unsigned phase_start;

      gap_by_phase   = '{0, 60, 0, 6};
      stall_by_phase = '{0, 0, 60, 6};
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_opcode    = OP_BEGIN;
      req_frame_len = '0;
      req_data_byte = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: stray byte with no frame open, empty frame, a bad length
      // that is swallowed, the longest bad length, a long legal frame cut off
      // by a begin, then a frame that applies two settings and hits a
      // protocol error on the last entry.
      send_byte(8'hFF);
      stray_words++;
      send_begin(24'd0);
      send_begin(24'd1);
      send_byte(8'h00);
      send_begin(24'hFF_FFFF);
      send_begin(24'hFF_FFFC);
      send_begin(24'(3 * ENTRY_BYTES));
      send_entry(ID_FRAME_SIZE, FRAME_LIMIT_MAX);
      send_entry(ID_WINDOW, WINDOW_MAX);
      send_entry(ID_ENABLE_PUSH, 32'd2);

      // Random phases with different idling; drain between them so the
      // sender waits out every pending result at least once.
      for (int p = 0; p < 4; p++) begin
         wait_for_reports();
         send_gap_pct  = gap_by_phase[p];
         rsp_stall_pct = stall_by_phase[p];
         phase_start   = words_sent - stray_words;
         while (words_sent - stray_words - phase_start < PHASE_WORDS) send_random_traffic();
      end

      // Drain: hold the sender, wait for every result, then keep watching for unexpected results.
      wait_for_reports();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
